### rtl/core/mad_pkg.sv
// package: shared types, widths and constants of the multichannel debouncer
package mad_pkg;

	localparam int GROUP_COUNT_DEF        = 4;
	localparam int CHANNELS_PER_GROUP_DEF = 16;

	localparam int GROUP_W   = 2;
	localparam int CHANNEL_W = 4;
	localparam int COUNT_W   = 8;
	localparam int DELAY_W   = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [DELAY_W-1:0] DELAY_ALIAS_ZERO = 8'hFF;

	localparam logic [CFG_IDX_W-1:0] REG_RISE_DELAY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_DELAY = 1'd1;

	typedef struct packed {
		logic               tripped;
		logic [COUNT_W-1:0] count;
	} chan_state_t;

	typedef struct packed {
		logic [DELAY_W-1:0] rise;
		logic [DELAY_W-1:0] fall;
	} delay_cfg_t;

endpackage

### rtl/core/mad_state_mem.sv
// per-channel state memory with registered read and reset-cleared valid bits
module mad_state_mem
	import mad_pkg::*;
#(
	parameter int DEPTH  = GROUP_COUNT_DEF * CHANNELS_PER_GROUP_DEF,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output chan_state_t       rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  chan_state_t       wr_data
);

	chan_state_t mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	chan_state_t rd_data_q;

	// entries never written read as the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/mad_update.sv
// next-state and qualified level of one channel for one sample
module mad_update
	import mad_pkg::*;
(
	input  chan_state_t cur,
	input  logic        sample,
	input  delay_cfg_t  delays,
	output chan_state_t nxt,
	output logic        level
);

	logic [DELAY_W-1:0] fall_eff;

	assign fall_eff = (delays.fall == DELAY_ALIAS_ZERO) ? '0 : delays.fall;

	always_comb begin
		nxt   = cur;
		level = 1'b1;
		if (!cur.tripped) begin
			if (sample) begin
				nxt.count = '0;
				level     = 1'b1;
			end else if (cur.count < delays.rise) begin
				nxt.count = cur.count + COUNT_W'(1);
				level     = 1'b1;
			end else begin
				nxt.tripped = 1'b1;
				level       = 1'b0;
			end
		end else begin
			if (!sample) begin
				nxt.count = '0;
				level     = 1'b0;
			end else if (cur.count < fall_eff) begin
				nxt.count = cur.count + COUNT_W'(1);
				level     = 1'b0;
			end else begin
				nxt.tripped = 1'b0;
				level       = 1'b1;
			end
		end
	end

endmodule

### rtl/core/multichannel_asymmetric_debouncer_unit.sv
// top level: registered memory read, then update, write-back and result register
// path: an accepted beat is held in the s1 registers, then in the result register; out_stall can hold it in s1
// throughput: one beat per cycle while out_stall does not hold s1; write-back forwards to a same-channel read
// the memory read port and the update step set the rate
// reset: delays clear to zero, every channel reads as idle with a zero count
module multichannel_asymmetric_debouncer_unit
	import mad_pkg::*;
#(
	parameter int GROUP_COUNT        = GROUP_COUNT_DEF,
	parameter int CHANNELS_PER_GROUP = CHANNELS_PER_GROUP_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [GROUP_W-1:0]    group_index,
	input  logic [CHANNEL_W-1:0]  channel_index,
	input  logic                  sample_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  qualified_level
);

	localparam int CHANNEL_TOTAL = GROUP_COUNT * CHANNELS_PER_GROUP;
	localparam int SLOT_W = (CHANNEL_TOTAL > 1) ? $clog2(CHANNEL_TOTAL) : 1;

	delay_cfg_t delays_q;

	logic              in_accept;
	logic              in_range;
	logic [SLOT_W-1:0] slot;

	logic              valid_s1;
	logic              in_range_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              sample_s1;
	logic              fwd_s1;
	chan_state_t       fwd_q;

	chan_state_t       rd_data;
	chan_state_t       cur;
	chan_state_t       nxt;
	logic              upd_level;

	logic              out_valid_q;
	logic              level_q;
	logic              out_room;
	logic              fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delays_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RISE_DELAY: delays_q.rise <= cfg_data[DELAY_W-1:0];
				REG_FALL_DELAY: delays_q.fall <= cfg_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_range = (int'(group_index) < GROUP_COUNT) &&
			(int'(channel_index) < CHANNELS_PER_GROUP);
	assign slot = SLOT_W'(int'(group_index) * CHANNELS_PER_GROUP + int'(channel_index));

	assign out_room  = !out_valid_q || !out_stall;
	assign fire_s1   = valid_s1 && out_room;
	assign in_stall  = valid_s1 && !out_room;
	assign in_accept = in_valid && !in_stall;

	mad_state_mem #(
		.DEPTH (CHANNEL_TOTAL),
		.ADDR_W(SLOT_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_accept && in_range),
		.rd_addr(slot),
		.rd_data(rd_data),
		.wr_en  (fire_s1 && in_range_s1),
		.wr_addr(slot_s1),
		.wr_data(nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// same channel written back while read: take the new value
	always_ff @(posedge clk) begin
		if (in_accept) begin
			in_range_s1 <= in_range;
			slot_s1     <= slot;
			sample_s1   <= sample_level;
			fwd_s1      <= fire_s1 && in_range_s1 && (slot_s1 == slot);
		end
		if (fire_s1) begin
			fwd_q <= nxt;
		end
	end

	assign cur = fwd_s1 ? fwd_q : rd_data;

	mad_update u_update (
		.cur   (cur),
		.sample(sample_s1),
		.delays(delays_q),
		.nxt   (nxt),
		.level (upd_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			level_q <= in_range_s1 ? upd_level : 1'b1;
		end
	end

	assign out_valid       = out_valid_q;
	assign qualified_level = level_q;

endmodule
